// ===== rtl/core/pwu_pkg.sv =====
// ----------------------------------------------------------------------------
// pwu_pkg
// Shared widths, register map, command/status types and controller states
// of the path waypoint upsampler.
// ----------------------------------------------------------------------------
package pwu_pkg;

  localparam int COORD_W    = 24;
  localparam int RES_W      = 16;
  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MAG_W      = COORD_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int D2_W       = PROD_W + 1;
  localparam int S_W        = RES_W + $clog2(MAX_POINTS);
  localparam int DCNT_W     = $clog2(MAG_W);

  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam int APB_ADDR_W = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = '0;
  localparam logic [RES_W-1:0]     RES_RESET      = RES_W'(77);

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic sq_s;
    logic s_cmp;
    logic div_step;
    logic emit_init;
    logic emit;
    logic start_out;
  } cmd_t;

  typedef struct packed {
    logic sq_le;
    logic cnt_max;
    logic n_zero;
    logic div_last;
    logic emit_last;
    logic out_free;
  } stat_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_SQX   = 9'b000000100,
    ST_SQY   = 9'b000001000,
    ST_SUM   = 9'b000010000,
    ST_SSQ   = 9'b000100000,
    ST_SCMP  = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

endpackage

// ===== rtl/core/pwu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwu_ctrl
// Controller: sequences distance squaring, count search, division and point
// emission for one waypoint at a time.
// ----------------------------------------------------------------------------
module pwu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           route_start,
  input  pwu_pkg::stat_t stat,
  output logic           in_stall,
  output pwu_pkg::cmd_t  cmd
);

  pwu_pkg::state_t state;
  pwu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      pwu_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = route_start ? pwu_pkg::ST_START : pwu_pkg::ST_SQX;
        end
      end
      pwu_pkg::ST_START: begin
        if (stat.out_free) begin
          cmd.start_out = 1'b1;
          state_next    = pwu_pkg::ST_IDLE;
        end
      end
      pwu_pkg::ST_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = pwu_pkg::ST_SQY;
      end
      pwu_pkg::ST_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = pwu_pkg::ST_SUM;
      end
      pwu_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = pwu_pkg::ST_SSQ;
      end
      pwu_pkg::ST_SSQ: begin
        cmd.sq_s   = 1'b1;
        state_next = pwu_pkg::ST_SCMP;
      end
      pwu_pkg::ST_SCMP: begin
        cmd.s_cmp = 1'b1;
        priority if (stat.sq_le && !stat.cnt_max) begin
          state_next = pwu_pkg::ST_SSQ;
        end else if (stat.sq_le || !stat.n_zero) begin
          state_next = pwu_pkg::ST_DIV;
        end else begin
          state_next = pwu_pkg::ST_IDLE;
        end
      end
      pwu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          cmd.emit_init = 1'b1;
          state_next    = pwu_pkg::ST_EMIT;
        end
      end
      pwu_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = pwu_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = pwu_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != pwu_pkg::ST_IDLE);

endmodule

// ===== rtl/core/pwu_dpath.sv =====
// ----------------------------------------------------------------------------
// pwu_dpath
// Datapath: deltas, shared squarer, count search, two-lane restoring divider,
// incremental interpolation and the output register.
// ----------------------------------------------------------------------------
module pwu_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pwu_pkg::cmd_t                        cmd,
  output pwu_pkg::stat_t                       stat,
  input  logic [pwu_pkg::RES_W-1:0]            res,
  input  logic signed [pwu_pkg::COORD_W-1:0]   way_x,
  input  logic signed [pwu_pkg::COORD_W-1:0]   way_y,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [pwu_pkg::COORD_W-1:0]   pt_x,
  output logic signed [pwu_pkg::COORD_W-1:0]   pt_y,
  output logic                                 last_of_run
);

  localparam int CW = pwu_pkg::COORD_W;
  localparam int MW = pwu_pkg::MAG_W;
  localparam int NW = pwu_pkg::CNT_W;

  logic signed [CW-1:0]         wx, wy, prev_x, prev_y;
  logic                         neg_x, neg_y;
  logic [MW-1:0]                mag_x, mag_y;
  logic [pwu_pkg::PROD_W-1:0]   prod;
  logic [pwu_pkg::D2_W-1:0]     d2;
  logic [pwu_pkg::S_W-1:0]      s;
  logic [NW-1:0]                cnt, n;
  logic [MW-1:0]                qx, qy;
  logic [NW-1:0]                rx, ry;
  logic [pwu_pkg::DCNT_W-1:0]   dcnt;
  logic [MW-1:0]                acc_x, acc_y;
  logic [NW-1:0]                rem_x, rem_y;

  logic signed [CW:0]           dx_full, dy_full;
  logic [CW:0]                  adx_full, ady_full;
  logic [MW-1:0]                mul_op;
  logic [NW:0]                  tx, ty, sum_rx, sum_ry;
  logic                         ge_x, ge_y, cy_x, cy_y;
  logic [NW-1:0]                rx_next, ry_next, rem_x_next, rem_y_next;
  logic [MW-1:0]                acc_x_next, acc_y_next;
  logic [CW-1:0]                ptx_next, pty_next;

  // delta against stored point, taken from the input ports at load
  assign dx_full  = {way_x[CW-1], way_x} - {prev_x[CW-1], prev_x};
  assign dy_full  = {way_y[CW-1], way_y} - {prev_y[CW-1], prev_y};
  assign adx_full = dx_full[CW] ? (CW+1)'(-dx_full) : (CW+1)'(dx_full);
  assign ady_full = dy_full[CW] ? (CW+1)'(-dy_full) : (CW+1)'(dy_full);

  always_comb begin
    priority if (cmd.sq_x) begin
      mul_op = mag_x;
    end else if (cmd.sq_y) begin
      mul_op = mag_y;
    end else begin
      mul_op = MW'(s);
    end
  end

  // restoring division step, both lanes
  assign tx      = {rx, qx[MW-1]};
  assign ty      = {ry, qy[MW-1]};
  assign ge_x    = tx >= {1'b0, n};
  assign ge_y    = ty >= {1'b0, n};
  assign rx_next = ge_x ? NW'(tx - {1'b0, n}) : NW'(tx);
  assign ry_next = ge_y ? NW'(ty - {1'b0, n}) : NW'(ty);

  // incremental floor(|d|*i/n): quotient plus carried remainder
  assign sum_rx     = {1'b0, rem_x} + {1'b0, rx};
  assign sum_ry     = {1'b0, rem_y} + {1'b0, ry};
  assign cy_x       = sum_rx >= {1'b0, n};
  assign cy_y       = sum_ry >= {1'b0, n};
  assign rem_x_next = cy_x ? NW'(sum_rx - {1'b0, n}) : NW'(sum_rx);
  assign rem_y_next = cy_y ? NW'(sum_ry - {1'b0, n}) : NW'(sum_ry);
  assign acc_x_next = acc_x + qx + MW'(cy_x);
  assign acc_y_next = acc_y + qy + MW'(cy_y);
  assign ptx_next   = neg_x ? (CW'(prev_x) - acc_x_next) : (CW'(prev_x) + acc_x_next);
  assign pty_next   = neg_y ? (CW'(prev_y) - acc_y_next) : (CW'(prev_y) + acc_y_next);

  assign stat.sq_le     = pwu_pkg::D2_W'(prod) <= d2;
  assign stat.cnt_max   = cnt == NW'(pwu_pkg::MAX_POINTS);
  assign stat.n_zero    = n == '0;
  assign stat.div_last  = dcnt == pwu_pkg::DCNT_W'(MW - 1);
  assign stat.emit_last = cnt == n;
  assign stat.out_free  = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      if (cmd.emit || cmd.start_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.start_out || (cmd.emit && stat.emit_last)) begin
        prev_x <= wx;
        prev_y <= wy;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wx    <= way_x;
      wy    <= way_y;
      neg_x <= dx_full[CW];
      neg_y <= dy_full[CW];
      mag_x <= MW'(adx_full);
      mag_y <= MW'(ady_full);
    end
    if (cmd.sq_x || cmd.sq_y || cmd.sq_s) begin
      prod <= pwu_pkg::PROD_W'(mul_op) * pwu_pkg::PROD_W'(mul_op);
    end
    if (cmd.sq_y) begin
      d2 <= pwu_pkg::D2_W'(prod);
    end
    if (cmd.sum) begin
      d2   <= d2 + pwu_pkg::D2_W'(prod);
      s    <= pwu_pkg::S_W'(res);
      cnt  <= NW'(1);
      n    <= '0;
      qx   <= mag_x;
      qy   <= mag_y;
      rx   <= '0;
      ry   <= '0;
      dcnt <= '0;
    end
    if (cmd.s_cmp && stat.sq_le) begin
      n <= cnt;
      if (!stat.cnt_max) begin
        cnt <= cnt + NW'(1);
        s   <= s + pwu_pkg::S_W'(res);
      end
    end
    if (cmd.div_step) begin
      qx   <= {qx[MW-2:0], ge_x};
      qy   <= {qy[MW-2:0], ge_y};
      rx   <= rx_next;
      ry   <= ry_next;
      dcnt <= dcnt + pwu_pkg::DCNT_W'(1);
    end
    if (cmd.emit_init) begin
      acc_x <= '0;
      acc_y <= '0;
      rem_x <= '0;
      rem_y <= '0;
      cnt   <= NW'(1);
    end
    if (cmd.emit) begin
      acc_x       <= acc_x_next;
      acc_y       <= acc_y_next;
      rem_x       <= rem_x_next;
      rem_y       <= rem_y_next;
      cnt         <= cnt + NW'(1);
      pt_x        <= ptx_next;
      pt_y        <= pty_next;
      last_of_run <= stat.emit_last;
    end
    if (cmd.start_out) begin
      pt_x        <= wx;
      pt_y        <= wy;
      last_of_run <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/path_waypoint_upsampler.sv =====
// ----------------------------------------------------------------------------
// path_waypoint_upsampler
// Densifies a route by linear interpolation between successive waypoints.
// ----------------------------------------------------------------------------
// One waypoint transaction is processed at a time. A route-start waypoint
// yields one point. Any other waypoint is first taken, its squared distance
// is formed on the shared 24x24 multiplier and its count n is found by a
// search of n+1 trials (64 when n saturates at 64). A waypoint closer than
// one resolution step ends there, yields no point and leaves the stored
// point unchanged. Otherwise a radix-2 division of both deltas by n follows,
// then one point per cycle is emitted while the output is not stalled.
// The output register lets the next waypoint be taken while the last point
// still waits. resolution sits at byte address 0 of the APB port and resets
// to 77.
// ----------------------------------------------------------------------------
module path_waypoint_upsampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwu_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [pwu_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [pwu_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 route_start,
  input  logic signed [pwu_pkg::COORD_W-1:0]   way_x,
  input  logic signed [pwu_pkg::COORD_W-1:0]   way_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pwu_pkg::COORD_W-1:0]   pt_x,
  output logic signed [pwu_pkg::COORD_W-1:0]   pt_y,
  output logic                                 last_of_run
);

  logic [pwu_pkg::RES_W-1:0] resolution;
  logic                      sel_res;
  pwu_pkg::cmd_t             cmd;
  pwu_pkg::stat_t            stat;

  assign pready  = 1'b1;
  assign sel_res = paddr[pwu_pkg::APB_ADDR_W-1:2] == pwu_pkg::REG_RESOLUTION;
  assign prdata  = sel_res ? pwu_pkg::APB_DATA_W'(resolution) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= pwu_pkg::RES_RESET;
    end else if (psel && penable && pwrite && pready && sel_res) begin
      resolution <= pwdata[pwu_pkg::RES_W-1:0];
    end
  end

  pwu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .route_start (route_start),
    .stat        (stat),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  pwu_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .res         (resolution),
    .way_x       (way_x),
    .way_y       (way_y),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .pt_x        (pt_x),
    .pt_y        (pt_y),
    .last_of_run (last_of_run)
  );

endmodule
